// File: rtl/adtb_pkg.sv
// Shared types and constants for the adaptive dual-threshold binarizer.
// No dependencies; used by the channel interfaces and the top level.
package adtb_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned LINE_W = 20;
  localparam int unsigned THR_W  = 16;
  localparam int unsigned ABS_W  = 21;   // |count - line| fits here
  localparam int unsigned Q_W    = 17;   // step magnitude in Q8.8

  // gray = (1868*B + 9617*G + 4899*R + 8192) >> 14
  localparam int unsigned GRAY_SUM_W = 23;
  localparam int unsigned GRAY_SHIFT = 14;
  localparam logic [GRAY_SUM_W-1:0] W_BLUE     = 23'd1868;
  localparam logic [GRAY_SUM_W-1:0] W_GREEN    = 23'd9617;
  localparam logic [GRAY_SUM_W-1:0] W_RED      = 23'd4899;
  localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND = 23'd8192;

  // |d|*256/7000 = 32*|d|/875; reciprocal floor(2^26/875), result off by at most one
  localparam int unsigned RECIP_W     = 17;
  localparam int unsigned PROD_W      = ABS_W + RECIP_W;
  localparam int unsigned NUM_W       = ABS_W + 5;
  localparam logic [RECIP_W-1:0] RECIP = 17'd76695;
  localparam logic [NUM_W-1:0] DIV_SCALED = 26'd875;

  localparam logic [THR_W-1:0] BRIGHT_THR_RST = 16'd40960;  // 160.0
  localparam logic [THR_W-1:0] COLOR_THR_RST  = 16'd12800;  // 50.0
  localparam logic [LINE_W-1:0] BRIGHT_LINE_RST = 20'd5500;
  localparam logic [LINE_W-1:0] COLOR_LINE_RST  = 20'd4000;

  // Q8.8 clamp bounds
  localparam logic [THR_W-1:0] FULL_Q88       = 16'd65280;  // 255.0
  localparam logic [THR_W-1:0] BLUE_BRIGHT_LO = 16'd39680;  // 155.0
  localparam logic [THR_W-1:0] BLUE_BRIGHT_HI = 16'd42240;  // 165.0
  localparam logic [THR_W-1:0] BLUE_COLOR_LO  = 16'd7680;   // 30.0
  localparam logic [THR_W-1:0] BLUE_COLOR_HI  = 16'd12800;  // 50.0
  localparam logic [THR_W-1:0] RED_BRIGHT_LO  = 16'd38400;  // 150.0
  localparam logic [THR_W-1:0] RED_BRIGHT_HI  = 16'd39680;  // 155.0
  localparam logic [THR_W-1:0] RED_COLOR_LO   = 16'd10240;  // 40.0
  localparam logic [THR_W-1:0] RED_COLOR_HI   = 16'd15360;  // 60.0

  typedef enum logic [1:0] {
    REG_TARGET_BLUE = 2'd0,
    REG_BRIGHT_LINE = 2'd1,
    REG_COLOR_LINE  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             frame_end;
  } pix_t;

  typedef struct packed {
    logic             bright_bit;
    logic             color_bit;
    logic             frame_done;
    logic [THR_W-1:0] bright_level;
  } res_t;

  typedef struct packed {
    logic [1:0]        index;
    logic [LINE_W-1:0] value;
  } cfg_t;

endpackage

// File: rtl/adtb_pix_if.sv
// Pixel input channel: valid/ready handshake carrying one BGR word.
// Depends on adtb_pkg.
interface adtb_pix_if;
  logic             valid;
  logic             ready;
  adtb_pkg::pix_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/adtb_res_if.sv
// Result output channel: valid/ready handshake carrying one result word.
// Depends on adtb_pkg.
interface adtb_res_if;
  logic             valid;
  logic             ready;
  adtb_pkg::res_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/adtb_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying index and data.
// Depends on adtb_pkg.
interface adtb_cfg_if;
  logic             valid;
  logic             ready;
  adtb_pkg::cfg_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/adaptive_dual_threshold_binarizer.sv
// Results pass the input register, then the result register; a frame_end result waits for UPD_APPLY.
// Throughput: one pixel per cycle while res_o is ready. After a frame_end word the pixel stage holds
//   while the threshold update (reciprocal multiply + fix-up) runs.
// Reset (rst_ni, async, active low): thresholds to 160.0 / 50.0, counts to zero,
//   config to target blue, lines 5500 / 4000, pipeline empty.
// Depends on adtb_pkg and the adtb_*_if channel interfaces.
module adaptive_dual_threshold_binarizer #(
  parameter int unsigned MAX_FRAME_PIXELS = 1048576
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  adtb_cfg_if.sink   cfg_i,
  adtb_pix_if.sink   pix_i,
  adtb_res_if.source res_o
);

  // Counts saturate at min(MAX_FRAME_PIXELS, 2^21-1)
  localparam int unsigned CNT_LIMIT =
    (MAX_FRAME_PIXELS < 2097151) ? MAX_FRAME_PIXELS : 2097151;
  localparam int unsigned CNT_W = $clog2(CNT_LIMIT + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CNT_LIMIT);

  // Threshold update sequencer
  typedef enum logic [4:0] {
    UPD_IDLE  = 5'b00001,
    UPD_DIFF  = 5'b00010,  // register |count - line| and sign
    UPD_MUL   = 5'b00100,  // reciprocal multiply
    UPD_FIX   = 5'b01000,  // remainder check, exact quotient
    UPD_APPLY = 5'b10000   // add, clamp, write thresholds, release result
  } upd_st_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                          target_q;
  logic [adtb_pkg::LINE_W-1:0]   bright_line_q, color_line_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q      <= 1'b1;
      bright_line_q <= adtb_pkg::BRIGHT_LINE_RST;
      color_line_q  <= adtb_pkg::COLOR_LINE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        adtb_pkg::REG_TARGET_BLUE: target_q      <= cfg_i.data.value[0];
        adtb_pkg::REG_BRIGHT_LINE: bright_line_q <= cfg_i.data.value;
        adtb_pkg::REG_COLOR_LINE:  color_line_q  <= cfg_i.data.value;
        default: ;  // unknown index: word dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic                         in_v_q, in_v_d;
  adtb_pkg::pix_t               in_q;
  logic                         out_v_q, out_v_d;
  adtb_pkg::res_t               out_q, out_d;

  logic [adtb_pkg::THR_W-1:0]   bright_thr_q, bright_thr_d;
  logic [adtb_pkg::THR_W-1:0]   color_thr_q, color_thr_d;
  logic [CNT_W-1:0]             bright_cnt_q, bright_cnt_d;
  logic [CNT_W-1:0]             color_cnt_q, color_cnt_d;

  upd_st_e                      upd_st_q, upd_st_d;
  logic                         upd_tgt_q, upd_tgt_d;
  logic [CNT_W-1:0]             fin_b_q, fin_b_d, fin_c_q, fin_c_d;
  logic [adtb_pkg::ABS_W-1:0]   abs_b_q, abs_b_d, abs_c_q, abs_c_d;
  logic                         neg_b_q, neg_b_d, neg_c_q, neg_c_d;
  logic [adtb_pkg::PROD_W-1:0]  prod_b_q, prod_b_d, prod_c_q, prod_c_d;
  logic [adtb_pkg::Q_W-1:0]     q_b_q, q_b_d, q_c_q, q_c_d;

  // ---------------------------------------------------------------------------
  // Handshake: the compute stage fires when it holds a pixel, no update runs and the result slot is free
  // ---------------------------------------------------------------------------
  logic fire;
  assign fire        = in_v_q && (upd_st_q == UPD_IDLE) && (!out_v_q || res_o.ready);
  assign pix_i.ready = !in_v_q || fire;

  assign res_o.valid = out_v_q;
  assign res_o.data  = out_q;

  // ---------------------------------------------------------------------------
  // Per-pixel datapath
  // ---------------------------------------------------------------------------
  logic [adtb_pkg::GRAY_SUM_W-1:0] gray_sum;
  logic [adtb_pkg::PIX_W-1:0]      gray, src, cdiff;
  logic                            bbit, cbit;
  logic [CNT_W-1:0]                b_inc, c_inc;

  always_comb begin
    gray_sum = adtb_pkg::W_BLUE  * adtb_pkg::GRAY_SUM_W'(in_q.blue)
             + adtb_pkg::W_GREEN * adtb_pkg::GRAY_SUM_W'(in_q.green)
             + adtb_pkg::W_RED   * adtb_pkg::GRAY_SUM_W'(in_q.red)
             + adtb_pkg::GRAY_ROUND;
    gray  = gray_sum[adtb_pkg::GRAY_SHIFT +: adtb_pkg::PIX_W];
    src   = target_q ? in_q.blue : in_q.red;
    cdiff = (src > in_q.green) ? (src - in_q.green) : '0;
    bbit  = {gray, 8'd0}  > bright_thr_q;
    cbit  = {cdiff, 8'd0} > color_thr_q;
    b_inc = (bbit && (bright_cnt_q < CNT_MAX)) ? bright_cnt_q + 1'b1 : bright_cnt_q;
    c_inc = (cbit && (color_cnt_q  < CNT_MAX)) ? color_cnt_q  + 1'b1 : color_cnt_q;
  end

  // ---------------------------------------------------------------------------
  // Update helpers
  // ---------------------------------------------------------------------------
  // trunc toward zero of (count - line)*256/7000 is the signed floor of |d|
  function automatic logic [adtb_pkg::ABS_W:0] abs_diff(
    input logic [CNT_W-1:0]              cnt,
    input logic [adtb_pkg::LINE_W-1:0]   line
  );
    logic signed [adtb_pkg::ABS_W:0] d;
    logic        [adtb_pkg::ABS_W:0] mag;
    d   = $signed({1'b0, adtb_pkg::ABS_W'(cnt)}) - $signed({2'b00, line});
    mag = d[adtb_pkg::ABS_W] ? -d : d;
    return {d[adtb_pkg::ABS_W], mag[adtb_pkg::ABS_W-1:0]};
  endfunction

  function automatic logic [adtb_pkg::Q_W-1:0] fix_quot(
    input logic [adtb_pkg::PROD_W-1:0] prod,
    input logic [adtb_pkg::ABS_W-1:0]  mag
  );
    logic [adtb_pkg::Q_W-1:0]   q_est;
    logic [adtb_pkg::NUM_W-1:0] rem;
    q_est = prod[adtb_pkg::PROD_W-1 -: adtb_pkg::Q_W];
    rem   = {mag, 5'd0} - adtb_pkg::DIV_SCALED * adtb_pkg::NUM_W'(q_est);
    return (rem >= adtb_pkg::DIV_SCALED) ? q_est + 1'b1 : q_est;
  endfunction

  function automatic logic [adtb_pkg::THR_W-1:0] apply_step(
    input logic [adtb_pkg::THR_W-1:0] thr,
    input logic [adtb_pkg::Q_W-1:0]   q,
    input logic                       neg,
    input logic [adtb_pkg::THR_W-1:0] lo,
    input logic [adtb_pkg::THR_W-1:0] hi
  );
    logic signed [18:0] t;
    logic signed [18:0] qs;
    qs = $signed({2'b00, q});
    t  = $signed({3'b000, thr}) + (neg ? -qs : qs);
    if (t > $signed({3'b000, adtb_pkg::FULL_Q88})) t = $signed({3'b000, adtb_pkg::FULL_Q88});
    if (t < 0) t = '0;
    if (t > $signed({3'b000, hi})) t = $signed({3'b000, hi});
    if (t < $signed({3'b000, lo})) t = $signed({3'b000, lo});
    return t[adtb_pkg::THR_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    in_v_d       = in_v_q;
    out_v_d      = out_v_q;
    out_d        = out_q;
    bright_thr_d = bright_thr_q;
    color_thr_d  = color_thr_q;
    bright_cnt_d = bright_cnt_q;
    color_cnt_d  = color_cnt_q;
    upd_st_d     = upd_st_q;
    upd_tgt_d    = upd_tgt_q;
    fin_b_d      = fin_b_q;
    fin_c_d      = fin_c_q;
    abs_b_d      = abs_b_q;
    abs_c_d      = abs_c_q;
    neg_b_d      = neg_b_q;
    neg_c_d      = neg_c_q;
    prod_b_d     = prod_b_q;
    prod_c_d     = prod_c_q;
    q_b_d        = q_b_q;
    q_c_d        = q_c_q;

    // input register
    if (fire) in_v_d = 1'b0;
    if (pix_i.valid && pix_i.ready) in_v_d = 1'b1;

    // result register drains
    if (out_v_q && res_o.ready) out_v_d = 1'b0;

    if (fire) begin
      out_d.bright_bit   = bbit;
      out_d.color_bit    = cbit;
      out_d.frame_done   = in_q.frame_end;
      out_d.bright_level = bright_thr_q;
      if (in_q.frame_end) begin
        // result held back until the new threshold is known
        out_v_d      = 1'b0;
        fin_b_d      = b_inc;
        fin_c_d      = c_inc;
        upd_tgt_d    = target_q;
        bright_cnt_d = '0;
        color_cnt_d  = '0;
        upd_st_d     = UPD_DIFF;
      end else begin
        out_v_d      = 1'b1;
        bright_cnt_d = b_inc;
        color_cnt_d  = c_inc;
      end
    end

    unique case (upd_st_q)
      UPD_IDLE: ;
      UPD_DIFF: begin
        {neg_b_d, abs_b_d} = abs_diff(fin_b_q, bright_line_q);
        {neg_c_d, abs_c_d} = abs_diff(fin_c_q, color_line_q);
        upd_st_d = UPD_MUL;
      end
      UPD_MUL: begin
        prod_b_d = adtb_pkg::PROD_W'(abs_b_q) * adtb_pkg::PROD_W'(adtb_pkg::RECIP);
        prod_c_d = adtb_pkg::PROD_W'(abs_c_q) * adtb_pkg::PROD_W'(adtb_pkg::RECIP);
        upd_st_d = UPD_FIX;
      end
      UPD_FIX: begin
        q_b_d    = fix_quot(prod_b_q, abs_b_q);
        q_c_d    = fix_quot(prod_c_q, abs_c_q);
        upd_st_d = UPD_APPLY;
      end
      UPD_APPLY: begin
        if (upd_tgt_q) begin
          bright_thr_d = apply_step(bright_thr_q, q_b_q, neg_b_q,
                                    adtb_pkg::BLUE_BRIGHT_LO, adtb_pkg::BLUE_BRIGHT_HI);
          color_thr_d  = apply_step(color_thr_q, q_c_q, neg_c_q,
                                    adtb_pkg::BLUE_COLOR_LO, adtb_pkg::BLUE_COLOR_HI);
        end else begin
          bright_thr_d = apply_step(bright_thr_q, q_b_q, neg_b_q,
                                    adtb_pkg::RED_BRIGHT_LO, adtb_pkg::RED_BRIGHT_HI);
          color_thr_d  = apply_step(color_thr_q, q_c_q, neg_c_q,
                                    adtb_pkg::RED_COLOR_LO, adtb_pkg::RED_COLOR_HI);
        end
        out_d.bright_level = bright_thr_d;
        out_v_d            = 1'b1;
        upd_st_d           = UPD_IDLE;
      end
      default: upd_st_d = UPD_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
      bright_thr_q <= adtb_pkg::BRIGHT_THR_RST;
      color_thr_q  <= adtb_pkg::COLOR_THR_RST;
      bright_cnt_q <= '0;
      color_cnt_q  <= '0;
      upd_st_q     <= UPD_IDLE;
    end else begin
      in_v_q       <= in_v_d;
      out_v_q      <= out_v_d;
      bright_thr_q <= bright_thr_d;
      color_thr_q  <= color_thr_d;
      bright_cnt_q <= bright_cnt_d;
      color_cnt_q  <= color_cnt_d;
      upd_st_q     <= upd_st_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (pix_i.valid && pix_i.ready) in_q <= pix_i.data;
    out_q     <= out_d;
    upd_tgt_q <= upd_tgt_d;
    fin_b_q   <= fin_b_d;
    fin_c_q   <= fin_c_d;
    abs_b_q   <= abs_b_d;
    abs_c_q   <= abs_c_d;
    neg_b_q   <= neg_b_d;
    neg_c_q   <= neg_c_d;
    prod_b_q  <= prod_b_d;
    prod_c_q  <= prod_c_d;
    q_b_q     <= q_b_d;
    q_c_q     <= q_c_d;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_fire_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_st_q != UPD_IDLE) |-> !fire)
    else $error("pixel stage fired during threshold update");

  a_frame_end_starts_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_q.frame_end) |=> (upd_st_q == UPD_DIFF) && !out_v_q)
    else $error("frame end did not start the update");

  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bright_cnt_q <= CNT_MAX) && (color_cnt_q <= CNT_MAX))
    else $error("count beyond saturation limit");

  a_bright_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bright_thr_q >= adtb_pkg::RED_BRIGHT_LO) && (bright_thr_q <= adtb_pkg::BLUE_BRIGHT_HI))
    else $error("brightness threshold outside clamp windows");

  a_color_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (color_thr_q >= adtb_pkg::BLUE_COLOR_LO) && (color_thr_q <= adtb_pkg::RED_COLOR_HI))
    else $error("colour threshold outside clamp windows");

endmodule
